// File: design/assert_macros.svh
// Assertion macros shared by the packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising clock edge out of reset.
`define SRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SRP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/srp_pkg.sv
// Types, constants and codes shared by the shelf rectangle packer.
package srp_pkg;

    localparam int unsigned DIM_W   = 13;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned ID_W    = 8;
    localparam int unsigned WASTE_W = 2 * DIM_W;

    localparam int unsigned DEF_MAX_SHELVES = 64;
    localparam int unsigned DEF_MAX_ATLAS   = 4096;

    localparam logic [DIM_W-1:0] ATLAS_SIZE_RESET = 13'd256;

    typedef enum logic [1:0] {
        STATUS_EXISTING = 2'd0,
        STATUS_NEW      = 2'd1,
        STATUS_NO_ROOM  = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_COMMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
        logic [ID_W-1:0]  atlas_id;
    } req_word_t;

    typedef struct packed {
        logic             placed;
        logic [ID_W-1:0]  result_atlas;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        status_t          status;
    } rsp_word_t;

    typedef struct packed {
        logic [POS_W-1:0] top;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] next_x;
        logic [DIM_W-1:0] free_w;
    } shelf_entry_t;

    typedef struct packed {
        logic busy;
        logic have_exact;
        logic have_best;
    } scan_status_t;

endpackage

// File: design/srp_shelf_mem.sv
// Shelf table storage: one write port and one registered read port.
module srp_shelf_mem #(
    parameter int unsigned DEPTH = srp_pkg::DEF_MAX_SHELVES,
    parameter int unsigned IDX_W = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  srp_pkg::shelf_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output srp_pkg::shelf_entry_t rd_data
);

    srp_pkg::shelf_entry_t mem [DEPTH];
    srp_pkg::shelf_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/srp_scan_unit.sv
// Shared compare and multiply unit that ranks one shelf per cycle.
module srp_scan_unit #(
    parameter int unsigned IDX_W = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         issue,
    input  logic [IDX_W-1:0]             issue_idx,
    input  srp_pkg::shelf_entry_t        rd_data,
    input  logic [srp_pkg::DIM_W-1:0]    rect_width,
    input  logic [srp_pkg::DIM_W-1:0]    rect_height,
    output srp_pkg::scan_status_t        scan_status,
    output srp_pkg::shelf_entry_t        exact_entry,
    output logic [IDX_W-1:0]             exact_idx,
    output srp_pkg::shelf_entry_t        best_entry,
    output logic [IDX_W-1:0]             best_idx
);

    // Stage one: read data from the shelf table is valid.
    logic                              s1_valid_reg;
    logic [IDX_W-1:0]                  s1_idx_reg;
    // Stage two: fit flags and waste product registered.
    logic                              s2_valid_reg;
    logic                              s2_exact_reg;
    logic                              s2_taller_reg;
    logic [srp_pkg::WASTE_W-1:0]       s2_waste_reg;
    logic [IDX_W-1:0]                  s2_idx_reg;
    srp_pkg::shelf_entry_t             s2_entry_reg;
    // Running winners.
    logic                              have_exact_reg;
    logic                              have_best_reg;
    logic [srp_pkg::WASTE_W-1:0]       min_waste_reg;
    srp_pkg::shelf_entry_t             exact_entry_reg;
    logic [IDX_W-1:0]                  exact_idx_reg;
    srp_pkg::shelf_entry_t             best_entry_reg;
    logic [IDX_W-1:0]                  best_idx_reg;

    logic                              fits;
    logic                              exact_hit;
    logic                              taller_hit;
    logic [srp_pkg::DIM_W-1:0]         height_diff;
    logic [srp_pkg::WASTE_W-1:0]       waste;
    logic                              take_exact;
    logic                              take_best;

    always_comb
    begin
        fits        = rect_width <= rd_data.free_w;
        exact_hit   = fits && (rect_height == rd_data.height);
        taller_hit  = fits && (rect_height < rd_data.height);
        height_diff = rd_data.height - rect_height;
        waste       = height_diff * rect_width;
    end

    always_comb
    begin
        take_exact = s2_valid_reg && s2_exact_reg && !have_exact_reg;
        // Strictly less keeps the earlier shelf on equal waste.
        take_best  = s2_valid_reg && s2_taller_reg
                     && (!have_best_reg || (s2_waste_reg < min_waste_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            have_exact_reg <= 1'b0;
            have_best_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (start)
            begin
                have_exact_reg <= 1'b0;
                have_best_reg  <= 1'b0;
            end
            else
            begin
                if (take_exact)
                begin
                    have_exact_reg <= 1'b1;
                end
                if (take_best)
                begin
                    have_best_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_idx_reg <= issue_idx;
        end
        if (s1_valid_reg)
        begin
            s2_exact_reg  <= exact_hit;
            s2_taller_reg <= taller_hit;
            s2_waste_reg  <= waste;
            s2_idx_reg    <= s1_idx_reg;
            s2_entry_reg  <= rd_data;
        end
        if (take_exact)
        begin
            exact_entry_reg <= s2_entry_reg;
            exact_idx_reg   <= s2_idx_reg;
        end
        if (take_best)
        begin
            min_waste_reg  <= s2_waste_reg;
            best_entry_reg <= s2_entry_reg;
            best_idx_reg   <= s2_idx_reg;
        end
    end

    assign scan_status.busy       = s1_valid_reg || s2_valid_reg;
    assign scan_status.have_exact = have_exact_reg;
    assign scan_status.have_best  = have_best_reg;
    assign exact_entry            = exact_entry_reg;
    assign exact_idx              = exact_idx_reg;
    assign best_entry             = best_entry_reg;
    assign best_idx               = best_idx_reg;

endmodule

// File: design/shelf_rect_packer_core.sv
// Top level of the shelf rectangle packer: sequencer, commit path and ports.
//
//   channel   direction   handshake                 word
//   req       in          req_valid / req_stall     req_word_t
//   rsp       out         rsp_valid / rsp_stall     rsp_word_t
//   cfg       in          cfg_wr_en                 atlas size, 13 bits
//
// A request runs from acceptance to the result word as one table read per shelf, a drain of
// the ranking pipeline and one commit (straight to commit with no shelves), then returns to idle.
// Reset empties the shelf table at once by clearing the shelf count.
// A new request is taken while the previous result word still waits on rsp_stall;
// the commit step waits only if that word has not left yet.
`include "assert_macros.svh"

module shelf_rect_packer_core #(
    parameter int unsigned MAX_SHELVES = srp_pkg::DEF_MAX_SHELVES,
    parameter int unsigned MAX_ATLAS   = srp_pkg::DEF_MAX_ATLAS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  srp_pkg::req_word_t         req,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output srp_pkg::rsp_word_t         rsp,
    input  logic                       cfg_wr_en,
    input  logic [srp_pkg::DIM_W-1:0]  cfg_wr_data
);

    localparam int unsigned IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_SHELVES + 1);

    srp_pkg::state_t                state_reg, state_next;
    logic [srp_pkg::DIM_W-1:0]      atlas_size_reg;
    logic [CNT_W-1:0]               shelf_count_reg;
    logic [srp_pkg::DIM_W-1:0]      used_height_reg;
    logic [IDX_W-1:0]               addr_reg;
    logic [srp_pkg::DIM_W-1:0]      width_reg;
    logic [srp_pkg::DIM_W-1:0]      height_reg;
    logic [srp_pkg::ID_W-1:0]       id_reg;
    logic                           rsp_valid_reg;
    srp_pkg::rsp_word_t             rsp_reg;

    logic                           accept;
    logic                           scan_last;
    logic                           rd_en;
    logic                           rsp_free;
    logic                           commit_en;

    srp_pkg::scan_status_t          scan_status;
    srp_pkg::shelf_entry_t          rd_data;
    srp_pkg::shelf_entry_t          exact_entry;
    srp_pkg::shelf_entry_t          best_entry;
    logic [IDX_W-1:0]               exact_idx;
    logic [IDX_W-1:0]               best_idx;

    logic [srp_pkg::DIM_W-1:0]      size;
    logic                           take_existing;
    logic                           new_fits;
    logic                           table_full;
    logic                           do_write;
    srp_pkg::shelf_entry_t          cur_entry;
    srp_pkg::shelf_entry_t          wr_entry;
    logic [IDX_W-1:0]               wr_idx;
    srp_pkg::rsp_word_t             rsp_next;

    assign accept    = req_valid && !req_stall;
    assign scan_last = CNT_W'(addr_reg) == (shelf_count_reg - CNT_W'(1));
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (shelf_count_reg == '0) ? srp_pkg::ST_COMMIT
                                                         : srp_pkg::ST_SCAN;
                end
            end
            srp_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = srp_pkg::ST_DRAIN;
                end
            end
            srp_pkg::ST_DRAIN:
            begin
                if (!scan_status.busy)
                begin
                    state_next = srp_pkg::ST_COMMIT;
                end
            end
            srp_pkg::ST_COMMIT:
            begin
                if (rsp_free)
                begin
                    state_next = srp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srp_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
        commit_en = 1'b0;
        unique case (state_reg)
            srp_pkg::ST_IDLE:   req_stall = 1'b0;
            srp_pkg::ST_SCAN:   rd_en     = 1'b1;
            srp_pkg::ST_DRAIN:  rd_en     = 1'b0;
            srp_pkg::ST_COMMIT: commit_en = rsp_free;
            default:            req_stall = 1'b1;
        endcase
    end

    // Commit datapath: pick the shelf, or open a new one, and form the result.
    always_comb
    begin
        size = (32'(atlas_size_reg) > MAX_ATLAS) ? srp_pkg::DIM_W'(MAX_ATLAS)
                                                 : atlas_size_reg;
        take_existing = scan_status.have_exact || scan_status.have_best;
        new_fits = ((width_reg <= size)
                    && (({1'b0, height_reg} + {1'b0, used_height_reg})
                        <= {1'b0, size}));
        table_full = 32'(shelf_count_reg) >= MAX_SHELVES;

        priority if (scan_status.have_exact)
        begin
            cur_entry = exact_entry;
            wr_idx    = exact_idx;
        end
        else if (scan_status.have_best)
        begin
            cur_entry = best_entry;
            wr_idx    = best_idx;
        end
        else
        begin
            cur_entry.top    = used_height_reg[srp_pkg::POS_W-1:0];
            cur_entry.height = height_reg;
            cur_entry.next_x = '0;
            cur_entry.free_w = size;
            wr_idx           = shelf_count_reg[IDX_W-1:0];
        end

        wr_entry        = cur_entry;
        wr_entry.next_x = cur_entry.next_x + width_reg;
        wr_entry.free_w = cur_entry.free_w - width_reg;

        do_write = take_existing || (new_fits && !table_full);

        rsp_next.placed       = do_write;
        rsp_next.result_atlas = do_write ? id_reg : '0;
        rsp_next.pos_x        = do_write ? cur_entry.next_x[srp_pkg::POS_W-1:0] : '0;
        rsp_next.pos_y        = do_write ? cur_entry.top : '0;
        priority if (take_existing)
        begin
            rsp_next.status = srp_pkg::STATUS_EXISTING;
        end
        else if (!new_fits)
        begin
            rsp_next.status = srp_pkg::STATUS_NO_ROOM;
        end
        else if (table_full)
        begin
            rsp_next.status = srp_pkg::STATUS_FULL;
        end
        else
        begin
            rsp_next.status = srp_pkg::STATUS_NEW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= srp_pkg::ST_IDLE;
            atlas_size_reg  <= srp_pkg::ATLAS_SIZE_RESET;
            shelf_count_reg <= '0;
            used_height_reg <= '0;
            addr_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                atlas_size_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                addr_reg <= '0;
            end
            else if (rd_en)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            if (commit_en && !take_existing && new_fits && !table_full)
            begin
                shelf_count_reg <= shelf_count_reg + CNT_W'(1);
                used_height_reg <= used_height_reg + height_reg;
            end
            if (commit_en)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            width_reg  <= req.rect_width;
            height_reg <= req.rect_height;
            id_reg     <= req.atlas_id;
        end
        if (commit_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    srp_shelf_mem #(
        .DEPTH (MAX_SHELVES),
        .IDX_W (IDX_W)
    ) u_shelf_mem (
        .clk     (clk),
        .wr_en   (commit_en && do_write),
        .wr_addr (wr_idx),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    srp_scan_unit #(
        .IDX_W (IDX_W)
    ) u_scan_unit (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .issue       (rd_en),
        .issue_idx   (addr_reg),
        .rd_data     (rd_data),
        .rect_width  (width_reg),
        .rect_height (height_reg),
        .scan_status (scan_status),
        .exact_entry (exact_entry),
        .exact_idx   (exact_idx),
        .best_entry  (best_entry),
        .best_idx    (best_idx)
    );

    `SRP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
                    32'(shelf_count_reg) <= MAX_SHELVES)
    `SRP_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept,
                     state_reg == srp_pkg::ST_SCAN || state_reg == srp_pkg::ST_COMMIT)
    `SRP_ASSERT_NEXT(a_commit_shows, clk, rst_n, commit_en, rsp_valid_reg)
    `SRP_ASSERT_NOW(a_placed_status, clk, rst_n, rsp_valid && rsp.placed,
                    rsp.status == srp_pkg::STATUS_EXISTING
                    || rsp.status == srp_pkg::STATUS_NEW)

endmodule

// File: test/tb_shelf_rect_packer_core.sv
// Self-checking testbench for the shelf rectangle packer core.
module tb_shelf_rect_packer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIM_W       = srp_pkg::DIM_W;
    localparam int unsigned POS_W       = srp_pkg::POS_W;
    localparam int unsigned ID_W        = srp_pkg::ID_W;
    localparam int unsigned SHELF_SLOTS = srp_pkg::DEF_MAX_SHELVES;
    localparam int unsigned ATLAS_CAP   = srp_pkg::DEF_MAX_ATLAS;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned SETTLE_CYC  = SHELF_SLOTS + 16;
    localparam int unsigned PRINT_CAP   = 40;

    localparam srp_pkg::status_t S_OLD  = srp_pkg::STATUS_EXISTING;
    localparam srp_pkg::status_t S_NEW  = srp_pkg::STATUS_NEW;
    localparam srp_pkg::status_t S_NONE = srp_pkg::STATUS_NO_ROOM;
    localparam srp_pkg::status_t S_FULL = srp_pkg::STATUS_FULL;

    typedef struct packed {
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [ID_W-1:0]    id;
        logic               typed;
        srp_pkg::rsp_word_t want;
    } directed_row_t;

    typedef struct packed {
        logic [DIM_W-1:0] atlas;
        logic [15:0]      count;
        logic [DIM_W-1:0] wmax;
        logic [DIM_W-1:0] hmax;
        logic             steady;
        logic             burst;
    } phase_t;

    localparam srp_pkg::rsp_word_t NO_ROOM_WORD = '{1'b0, 8'd0, 12'd0, 12'd0, S_NONE};
    localparam srp_pkg::rsp_word_t NOT_TYPED    = '0;

    // Rows with a typed result are read straight off the packing rules; the rest
    // are predicted. The early rows build three shelves in a 256 pixel atlas.
    localparam directed_row_t STEPS [17] = '{
        '{13'd10,   13'd20,   8'h01, 1'b1, '{1'b1, 8'h01, 12'd0,  12'd0,  S_NEW}},
        '{13'd10,   13'd20,   8'hFE, 1'b1, '{1'b1, 8'hFE, 12'd10, 12'd0,  S_OLD}},
        '{13'd5,    13'd10,   8'h33, 1'b0, NOT_TYPED},
        '{13'd0,    13'd0,    8'h80, 1'b0, NOT_TYPED},
        '{13'd256,  13'd16,   8'hFF, 1'b1, '{1'b1, 8'hFF, 12'd0,  12'd20, S_NEW}},
        '{13'd257,  13'd1,    8'h5A, 1'b1, NO_ROOM_WORD},
        '{13'd1,    13'd4096, 8'hA5, 1'b1, NO_ROOM_WORD},
        '{13'd8191, 13'd8191, 8'hFF, 1'b1, NO_ROOM_WORD},
        '{13'd4096, 13'd1,    8'h00, 1'b1, NO_ROOM_WORD},
        '{13'd1,    13'd220,  8'h11, 1'b1, '{1'b1, 8'h11, 12'd0,  12'd36, S_NEW}},
        '{13'd1,    13'd1,    8'h22, 1'b0, NOT_TYPED},
        '{13'd0,    13'd16,   8'h44, 1'b0, NOT_TYPED},
        '{13'd230,  13'd19,   8'h66, 1'b0, NOT_TYPED},
        '{13'd0,    13'd5,    8'h77, 1'b0, NOT_TYPED},
        '{13'd1,    13'd1,    8'h88, 1'b0, NOT_TYPED},
        '{13'd1,    13'd0,    8'h99, 1'b0, NOT_TYPED},
        '{13'd4095, 13'd0,    8'hAA, 1'b0, NOT_TYPED}
    };

    localparam phase_t PHASES [6] = '{
        '{13'd1024, 16'd70,  13'd96,  13'd24,  1'b0, 1'b0},
        '{13'd300,  16'd50,  13'd64,  13'd24,  1'b1, 1'b0},
        '{13'd0,    16'd30,  13'd32,  13'd16,  1'b0, 1'b0},
        '{13'd8191, 16'd220, 13'd512, 13'd64,  1'b0, 1'b1},
        '{13'd4096, 16'd200, 13'd256, 13'd128, 1'b0, 1'b0},
        '{13'd256,  16'd160, 13'd64,  13'd32,  1'b0, 1'b0}
    };

    localparam logic [DIM_W-1:0] EXTREME_DIMS [5] = '{13'd0, 13'd1, 13'd4095, 13'd4096,
                                                      13'd8191};

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               req_valid   = 1'b0;
    logic               req_stall;
    srp_pkg::req_word_t req         = '0;
    logic               rsp_valid;
    logic               rsp_stall   = 1'b0;
    srp_pkg::rsp_word_t rsp;
    logic               cfg_wr_en   = 1'b0;
    logic [DIM_W-1:0]   cfg_wr_data = '0;

    // Packer state as the predictor sees it.
    logic [POS_W-1:0] pk_top    [SHELF_SLOTS];
    logic [DIM_W-1:0] pk_height [SHELF_SLOTS];
    logic [DIM_W-1:0] pk_next_x [SHELF_SLOTS];
    logic [DIM_W-1:0] pk_free   [SHELF_SLOTS];
    int unsigned      pk_count  = 0;
    logic [DIM_W-1:0] pk_used   = '0;
    logic [DIM_W-1:0] pk_atlas  = srp_pkg::ATLAS_SIZE_RESET;

    srp_pkg::rsp_word_t pending_placements [$];
    logic [DIM_W-1:0]   fav_h [4];
    bit                 steady        = 1'b0;
    bit                 long_hold_due = 1'b0;
    int unsigned        err_cnt       = 0;
    int unsigned        words_seen    = 0;
    int unsigned        status_seen [4] = '{0, 0, 0, 0};

    shelf_rect_packer_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Scans the shelves in the order they were opened and commits the placement.
    function automatic srp_pkg::rsp_word_t place_rect(input srp_pkg::req_word_t rq);
        srp_pkg::rsp_word_t r;
        int unsigned        lim;
        int unsigned        waste;
        int unsigned        least_waste;
        int unsigned        i;
        int                 pick;
        int                 best;
        bit                 have_best;
        r = '0;
        r.status = S_NONE;
        lim = (pk_atlas > ATLAS_CAP) ? ATLAS_CAP : pk_atlas;
        pick = -1;
        best = 0;
        have_best = 1'b0;
        least_waste = 0;
        for (i = 0; i < pk_count && pick < 0; i++)
        begin
            if (rq.rect_width <= pk_free[i])
            begin
                if (rq.rect_height == pk_height[i])
                begin
                    pick = i;
                end
                else if (rq.rect_height < pk_height[i])
                begin
                    waste = (pk_height[i] - rq.rect_height) * rq.rect_width;
                    if (!have_best || waste < least_waste)
                    begin
                        have_best = 1'b1;
                        least_waste = waste;
                        best = i;
                    end
                end
            end
        end
        if (pick < 0 && have_best)
            pick = best;
        if (pick >= 0)
        begin
            r.status = S_OLD;
        end
        else if (rq.rect_height + pk_used <= lim && rq.rect_width <= lim)
        begin
            if (pk_count >= SHELF_SLOTS)
            begin
                r.status = S_FULL;
            end
            else
            begin
                pick = pk_count;
                pk_top[pick]    = pk_used[POS_W-1:0];
                pk_height[pick] = rq.rect_height;
                pk_next_x[pick] = '0;
                pk_free[pick]   = DIM_W'(lim);
                pk_count++;
                pk_used = pk_used + rq.rect_height;
                r.status = S_NEW;
            end
        end
        if (pick >= 0)
        begin
            r.placed       = 1'b1;
            r.result_atlas = rq.atlas_id;
            r.pos_x        = pk_next_x[pick][POS_W-1:0];
            r.pos_y        = pk_top[pick];
            pk_next_x[pick] = pk_next_x[pick] + rq.rect_width;
            pk_free[pick]   = pk_free[pick] - rq.rect_width;
        end
        return r;
    endfunction

    // Most requests reuse a few heights so that exact and near fits happen often.
    function automatic srp_pkg::req_word_t draw_rect(input int unsigned wmax,
                                                     input int unsigned hmax);
        srp_pkg::req_word_t rq;
        int unsigned        roll;
        roll = $urandom_range(0, 99);
        rq.atlas_id   = ID_W'($urandom);
        rq.rect_width = DIM_W'($urandom_range(1, wmax));
        if (roll < 60)
        begin
            rq.rect_height = fav_h[$urandom_range(0, 3)];
        end
        else if (roll < 85)
        begin
            rq.rect_height = DIM_W'($urandom_range(1, hmax));
        end
        else if (roll < 92)
        begin
            rq.rect_width  = EXTREME_DIMS[$urandom_range(0, 4)];
            rq.rect_height = EXTREME_DIMS[$urandom_range(0, 4)];
        end
        else
        begin
            rq.rect_width  = DIM_W'($urandom);
            rq.rect_height = DIM_W'($urandom);
        end
        if ($urandom_range(0, 19) == 0)
            rq.rect_width = '0;
        return rq;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want_v);
        if (err_cnt < PRINT_CAP)
            $display("%0t ns: %0s mismatch on word %0d: got %0d, expected %0d",
                     $realtime, what, words_seen, got, want_v);
        err_cnt++;
    endtask

    // Entered at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_rect(input srp_pkg::req_word_t rq, input bit typed,
                              input srp_pkg::rsp_word_t want);
        int unsigned        gap;
        srp_pkg::rsp_word_t calc;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= rq;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        calc = place_rect(rq);
        pending_placements.insert(pending_placements.size(), typed ? want : calc);
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int unsigned hold;
        forever
        begin
            @(negedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                hold = LONG_HOLD;
            end
            else
            begin
                hold = steady ? 0 : $urandom_range(0, 4);
            end
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : placement_check
        srp_pkg::rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_placements.size() == 0)
            begin
                report_mismatch("unexpected result word", 1, 0);
            end
            else
            begin
                want = pending_placements.pop_front();
                if (rsp.placed !== want.placed)
                    report_mismatch("placed", rsp.placed, want.placed);
                if (rsp.result_atlas !== want.result_atlas)
                    report_mismatch("result_atlas", rsp.result_atlas, want.result_atlas);
                if (rsp.pos_x !== want.pos_x)
                    report_mismatch("pos_x", rsp.pos_x, want.pos_x);
                if (rsp.pos_y !== want.pos_y)
                    report_mismatch("pos_y", rsp.pos_y, want.pos_y);
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                status_seen[int'(want.status)]++;
            end
            words_seen++;
        end
    end

    initial
    begin : stimulus
        int unsigned k;
        int unsigned p;
        int unsigned n;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (k = 0; k < $size(STEPS); k++)
            offer_rect(srp_pkg::req_word_t'({STEPS[k].w, STEPS[k].h, STEPS[k].id}),
                       STEPS[k].typed, STEPS[k].want);
        for (p = 0; p < $size(PHASES); p++)
        begin
            // The atlas size only changes once every placement so far is back.
            req_valid <= 1'b0;
            while (pending_placements.size() != 0)
                @(posedge clk);
            @(negedge clk);
            cfg_wr_data <= PHASES[p].atlas;
            cfg_wr_en   <= 1'b1;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            pk_atlas = PHASES[p].atlas;
            steady = PHASES[p].steady;
            if (PHASES[p].burst)
                long_hold_due = 1'b1;
            for (k = 0; k < 4; k++)
                fav_h[k] = DIM_W'($urandom_range(1, PHASES[p].hmax));
            for (n = 0; n < PHASES[p].count; n++)
                offer_rect(draw_rect(PHASES[p].wmax, PHASES[p].hmax), 1'b0, NOT_TYPED);
        end
        req_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        $display("Checked %0d result words over atlas sizes 1024, 300, 0, 8191, 4096, 256;",
                 words_seen);
        $display("%0d existing-shelf, %0d new-shelf, %0d no-room, %0d table-full, %0d shelves.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], pk_count);
        if (err_cnt == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("Timed out with %0d result words still outstanding.",
                 pending_placements.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
